FILE: rtl/atrf_pkg.sv
// Package for the API transmit-request framer.
// Holds frame constants, byte positions and the result struct.
// Used by atrf_seq, atrf_obuf and api_transmit_request_framer_top.
`default_nettype none

package atrf_pkg;

    localparam logic [7:0] START_DELIM  = 8'h7E;
    localparam logic [7:0] FRAME_TYPE   = 8'h10;
    localparam logic [7:0] ADDR16_HI    = 8'hFF;
    localparam logic [7:0] ADDR16_LO    = 8'hFE;
    localparam logic [7:0] LEN_OVERHEAD = 8'd14;
    localparam logic [7:0] MAX_PAYLOAD  = 8'd238;

    // Result position within one transaction: header bytes first, then
    // payload, then checksum. A continuing transaction starts at payload.
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_START   = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 5'd3;
    localparam logic [POS_W-1:0] POS_FID     = 5'd4;
    localparam logic [POS_W-1:0] POS_A16_HI  = 5'd13;
    localparam logic [POS_W-1:0] POS_A16_LO  = 5'd14;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd17;
    localparam logic [POS_W-1:0] POS_CKSUM   = 5'd18;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } t_res;

endpackage

`default_nettype wire

FILE: rtl/atrf_seq.sv
// Frame sequencer: input register, byte position counter and frame state.
// Emits one frame byte per cycle while i_take is high; depends on atrf_pkg.
`default_nettype none

module atrf_seq
    import atrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic [7:0] i_payload_length,
    output logic            o_res_vld,
    output t_res            o_res,
    input  wire logic       i_take
);

    logic             r_vld, n_vld;
    logic [7:0]       r_data, n_data;
    logic [7:0]       r_len, n_len;
    logic             r_open, n_open;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_fid, n_fid;
    logic [7:0]       r_rem, n_rem;
    logic [7:0]       r_sum, n_sum;

    logic       fire;
    logic       is_pay;
    logic       is_ck;
    logic       pay_then_ck;
    logic       last;
    logic [7:0] hdr_byte;
    logic [7:0] cur_byte;

    always_comb begin
        unique case (r_pos)
            POS_START:  hdr_byte = START_DELIM;
            POS_LEN_HI: hdr_byte = 8'h00;
            POS_LEN_LO: hdr_byte = LEN_OVERHEAD + r_len;
            POS_TYPE:   hdr_byte = FRAME_TYPE;
            POS_FID:    hdr_byte = r_fid;
            POS_A16_HI: hdr_byte = ADDR16_HI;
            POS_A16_LO: hdr_byte = ADDR16_LO;
            default:    hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        is_pay      = (r_pos == POS_PAYLOAD) && !(r_open && (r_len == 8'd0));
        is_ck       = (r_pos == POS_CKSUM) ||
                      ((r_pos == POS_PAYLOAD) && r_open && (r_len == 8'd0));
        pay_then_ck = r_open ? (r_len == 8'd1) : (r_rem == 8'd1);
        last        = is_ck || (is_pay && !pay_then_ck);
        cur_byte    = is_ck ? ~r_sum : (is_pay ? r_data : hdr_byte);
        fire        = r_vld && i_take;
        o_ready     = !r_vld || (fire && last);
    end

    always_comb begin
        n_vld  = r_vld;
        n_data = r_data;
        n_len  = r_len;
        n_open = r_open;
        n_pos  = r_pos;
        n_fid  = r_fid;
        n_rem  = r_rem;
        n_sum  = r_sum;

        if (fire) begin
            if (is_pay) begin
                n_sum = r_sum + r_data;
                n_rem = r_open ? (r_len - 8'd1) : (r_rem - 8'd1);
            end else if (is_ck) begin
                n_sum = 8'h00;
                n_fid = r_fid + 8'd1;
            end else if (r_pos >= POS_TYPE) begin
                n_sum = r_sum + hdr_byte;
            end
            if (last) begin
                n_vld = 1'b0;
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end

        // Load the next transaction; it opens a frame when nothing is owed.
        if (i_valid && o_ready) begin
            n_vld  = 1'b1;
            n_data = i_payload_byte;
            n_len  = (i_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : i_payload_length;
            n_open = (n_rem == 8'd0);
            n_pos  = n_open ? POS_START : POS_PAYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_fid <= 8'h00;
            r_rem <= 8'h00;
            r_sum <= 8'h00;
        end else begin
            r_vld <= n_vld;
            r_fid <= n_fid;
            r_rem <= n_rem;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_len  <= n_len;
        r_open <= n_open;
        r_pos  <= n_pos;
    end

    assign o_res_vld       = r_vld;
    assign o_res.out_byte  = cur_byte;
    assign o_res.frame_end = is_ck;
    assign o_res.run_last  = last;

endmodule

`default_nettype wire

FILE: rtl/atrf_obuf.sv
// Output register for framer results.
// Holds one result until taken downstream; depends on atrf_pkg.
`default_nettype none

module atrf_obuf
    import atrf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_vld,
    input  t_res      i_res,
    output logic      o_take,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_ready
);

    logic r_vld, n_vld;
    t_res r_res, n_res;

    always_comb begin
        o_take = !r_vld || i_ready;
        n_vld  = r_vld;
        n_res  = r_res;
        if (o_take) begin
            n_vld = i_vld;
            n_res = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: rtl/api_transmit_request_framer_top.sv
// Channel  | Handshake            | Payload
// input    | i_valid / o_ready    | i_payload_byte[7:0], i_payload_length[7:0]
// output   | o_valid / i_ready    | o_out_byte[7:0], o_frame_end, o_run_last
//
// One result byte leaves per cycle while i_ready is high; a transaction is
// 1 to 19 bytes, set by the sequencer's byte position counter: 17 header
// bytes when it opens a frame, a payload byte if any, a checksum at frame end.
// Next transaction is taken in the cycle its predecessor's last byte moves
// to the output register. Synchronous active-low reset clears frame state.
// Depends on atrf_pkg, atrf_seq and atrf_obuf.
`default_nettype none

module api_transmit_request_framer_top
    import atrf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic [7:0] i_payload_length,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_end,
    output logic            o_run_last
);

    logic w_seq_vld;
    t_res w_seq_res;
    logic w_take;
    t_res w_out_res;

    atrf_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (i_payload_length),
        .o_res_vld        (w_seq_vld),
        .o_res            (w_seq_res),
        .i_take           (w_take)
    );

    atrf_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_seq_vld),
        .i_res   (w_seq_res),
        .o_take  (w_take),
        .o_valid (o_valid),
        .o_res   (w_out_res),
        .i_ready (i_ready)
    );

    assign o_out_byte  = w_out_res.out_byte;
    assign o_frame_end = w_out_res.frame_end;
    assign o_run_last  = w_out_res.run_last;

    a_ck_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seq_vld && w_seq_res.frame_end |-> w_seq_res.run_last)
        else $error("checksum byte not marked as last of its transaction");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> w_seq_vld)
        else $error("accepted transaction not held in sequencer");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_seq_vld))
        else $error("output became valid without a sequencer byte");

endmodule

`default_nettype wire
